[sv/bc1_pkg.sv]
// ----------------------------------------------------------------------------
// BC1 decoder package
// Shared types and constants for the BC1 block decoder.
// ----------------------------------------------------------------------------
package bc1_pkg;

   localparam int PIXELS_PER_BLOCK = 16;
   localparam int PIXEL_CNT_W      = $clog2(PIXELS_PER_BLOCK);
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] ALPHA_OPAQUE      = 8'hff;
   localparam logic [7:0] ALPHA_TRANSPARENT = 8'h00;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } color_type;

   typedef struct packed {
      color_type [3:0] palette;
      logic [31:0]     index_bits;
   } block_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] count;
      logic                   full;
      logic                   empty;
   } queue_status_type;

endpackage

[sv/bc1_if.sv]
// ----------------------------------------------------------------------------
// BC1 decoder channels
// Valid/ready channels for compressed blocks and decoded pixels.
// ----------------------------------------------------------------------------
interface bc1_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] endpoint_zero;
   logic [15:0] endpoint_one;
   logic [31:0] index_bits;

   modport source (output valid, output endpoint_zero, output endpoint_one,
                   output index_bits, input ready);
   modport sink (input valid, input endpoint_zero, input endpoint_one,
                 input index_bits, output ready);
endinterface

interface bc1_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic [1:0] column;
   logic [1:0] row;
   logic       last_pixel;

   modport source (output valid, output red, output green, output blue, output alpha,
                   output column, output row, output last_pixel, input ready);
   modport sink (input valid, input red, input green, input blue, input alpha,
                 input column, input row, input last_pixel, output ready);
endinterface

[sv/bc1_front.sv]
// ----------------------------------------------------------------------------
// BC1 front end
// Accepts a compressed block, selects the palette mode and builds the palette.
// ----------------------------------------------------------------------------
module bc1_front (
   bc1_req_if.sink            req,
   output logic               push_valid,
   output bc1_pkg::block_type push_data,
   input  logic               push_ready
);
   import bc1_pkg::*;

   localparam int SUM_W      = 10;
   localparam int DIV3_SHIFT = 11;
   localparam int DIV3_MUL   = ((1 << DIV3_SHIFT) + 2) / 3;
   localparam int PROD_W     = SUM_W + DIV3_SHIFT;

   logic [2:0][7:0]       chan_zero;
   logic [2:0][7:0]       chan_one;
   logic                  four_color;
   logic [2:0][SUM_W-1:0] sum_two;
   logic [2:0][SUM_W-1:0] sum_three;
   logic [2:0][PROD_W-1:0] prod_two;
   logic [2:0][PROD_W-1:0] prod_three;
   color_type             color_zero;
   color_type             color_one;
   color_type             color_two;
   color_type             color_three;

   always_comb begin
      chan_zero[0] = {req.endpoint_zero[15:11], req.endpoint_zero[15:13]};
      chan_zero[1] = {req.endpoint_zero[10:5], req.endpoint_zero[10:9]};
      chan_zero[2] = {req.endpoint_zero[4:0], req.endpoint_zero[4:2]};
      chan_one[0]  = {req.endpoint_one[15:11], req.endpoint_one[15:13]};
      chan_one[1]  = {req.endpoint_one[10:5], req.endpoint_one[10:9]};
      chan_one[2]  = {req.endpoint_one[4:0], req.endpoint_one[4:2]};
      four_color   = req.endpoint_zero > req.endpoint_one;
   end

   // Division by three is a multiply by a rounded-up reciprocal; it is exact
   // for every sum below 2048.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum_two[c]    = {chan_zero[c], 1'b0} + SUM_W'(chan_one[c]);
         sum_three[c]  = SUM_W'(chan_zero[c]) + {chan_one[c], 1'b0};
         prod_two[c]   = PROD_W'(sum_two[c]) * PROD_W'(DIV3_MUL);
         prod_three[c] = PROD_W'(sum_three[c]) * PROD_W'(DIV3_MUL);
      end
   end

   always_comb begin
      color_zero  = '{red: chan_zero[0], green: chan_zero[1], blue: chan_zero[2],
                      alpha: ALPHA_OPAQUE};
      color_one   = '{red: chan_one[0], green: chan_one[1], blue: chan_one[2],
                      alpha: ALPHA_OPAQUE};
      color_two   = '{red: '0, green: '0, blue: '0, alpha: ALPHA_OPAQUE};
      color_three = '{red: '0, green: '0, blue: '0, alpha: ALPHA_TRANSPARENT};
      if (four_color) begin
         color_two.red     = prod_two[0][DIV3_SHIFT +: 8];
         color_two.green   = prod_two[1][DIV3_SHIFT +: 8];
         color_two.blue    = prod_two[2][DIV3_SHIFT +: 8];
         color_three.red   = prod_three[0][DIV3_SHIFT +: 8];
         color_three.green = prod_three[1][DIV3_SHIFT +: 8];
         color_three.blue  = prod_three[2][DIV3_SHIFT +: 8];
         color_three.alpha = ALPHA_OPAQUE;
      end else begin
         color_two.red   = 8'((9'(chan_zero[0]) + 9'(chan_one[0])) >> 1);
         color_two.green = 8'((9'(chan_zero[1]) + 9'(chan_one[1])) >> 1);
         color_two.blue  = 8'((9'(chan_zero[2]) + 9'(chan_one[2])) >> 1);
      end
   end

   assign push_valid           = req.valid;
   assign req.ready            = push_ready;
   assign push_data.palette    = {color_three, color_two, color_one, color_zero};
   assign push_data.index_bits = req.index_bits;

endmodule

[sv/bc1_queue.sv]
// ----------------------------------------------------------------------------
// BC1 block queue
// Short queue of decoded palettes between the front end and the pixel stage.
// ----------------------------------------------------------------------------
module bc1_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  bc1_pkg::block_type        push_data,
   output logic                      push_ready,
   output logic                      pop_valid,
   output bc1_pkg::block_type        pop_data,
   input  logic                      pop_ready,
   output bc1_pkg::queue_status_type status
);
   import bc1_pkg::*;

   block_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign status.count = count_ff;
   assign status.full  = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign push_ready   = !status.full;
   assign pop_valid    = !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];
   assign push         = push_valid && push_ready;
   assign pop          = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/bc1_back.sv]
// ----------------------------------------------------------------------------
// BC1 pixel stage
// Walks a queued block and emits its sixteen pixels, one word per cycle while rsp.ready holds.
// ----------------------------------------------------------------------------
module bc1_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  bc1_pkg::block_type pop_data,
   output logic               pop_ready,
   bc1_rsp_if.source          rsp
);
   import bc1_pkg::*;

   block_type              block_ff, block_in;
   logic                   busy_ff, busy_in;
   logic [PIXEL_CNT_W-1:0] count_ff, count_in;
   logic                   out_valid_ff, out_valid_in;
   color_type              color_ff, color_in;
   logic [PIXEL_CNT_W-1:0] pos_ff, pos_in;
   logic                   last_ff, last_in;
   logic                   out_free;
   logic                   at_last;
   logic                   emit;
   logic [1:0]             sel;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign at_last   = count_ff == PIXEL_CNT_W'(PIXELS_PER_BLOCK - 1);
   assign emit      = busy_ff && out_free;
   assign pop_ready = !busy_ff || (emit && at_last);
   assign sel       = block_ff.index_bits[{count_ff, 1'b0} +: 2];

   always_comb begin
      block_in     = block_ff;
      busy_in      = busy_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      color_in     = color_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      if (emit) begin
         count_in     = count_ff + 1'b1;
         out_valid_in = 1'b1;
         color_in     = block_ff.palette[sel];
         pos_in       = count_ff;
         last_in      = at_last;
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
      if (pop_valid && pop_ready) begin
         block_in = pop_data;
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      color_ff <= color_in;
      pos_ff   <= pos_in;
      last_ff  <= last_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.red        = color_ff.red;
   assign rsp.green      = color_ff.green;
   assign rsp.blue       = color_ff.blue;
   assign rsp.alpha      = color_ff.alpha;
   assign rsp.column     = pos_ff[1:0];
   assign rsp.row        = pos_ff[3:2];
   assign rsp.last_pixel = last_ff;

endmodule

[sv/bc1_block_decoder.sv]
// ----------------------------------------------------------------------------
// BC1 block decoder
// Decodes one 64-bit BC1 block into sixteen RGBA8 pixels in row-major order.
// ----------------------------------------------------------------------------
// Each accepted block yields sixteen pixel words, one per cycle while the
// receiver is ready, with the last one flagged. The palette is built as the
// block is taken in and parked in a two-block queue, so the input side keeps
// accepting while the output side stalls until that queue is full, and
// consecutive blocks leave without a gap. In an empty decoder the first pixel
// passes through the queue entry, the block register and the pixel register.
module bc1_block_decoder (
   input logic       clock,
   input logic       reset,
   bc1_req_if.sink   req_chan,
   bc1_rsp_if.source rsp_chan
);
   import bc1_pkg::*;

   logic             push_valid;
   logic             push_ready;
   block_type        push_data;
   logic             pop_valid;
   logic             pop_ready;
   block_type        pop_data;
   queue_status_type queue_status;

   bc1_front u_front (
      .req        (req_chan),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   bc1_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready),
      .status     (queue_status)
   );

   bc1_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp       (rsp_chan)
   );

   assert property (@(posedge clock) disable iff (reset)
      queue_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("Block queue count exceeds its depth.");

   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !queue_status.empty)
      else $error("Accepted block did not land in the queue.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_pixel |=> rsp_chan.valid)
      else $error("Pixel word missing in the middle of a block.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.last_pixel |-> rsp_chan.column == 2'd3 && rsp_chan.row == 2'd3)
      else $error("Last pixel flag on a pixel other than the final one.");

endmodule

[test/bc1_pixel_checker.sv]
// ----------------------------------------------------------------------------
// BC1 pixel checker
// Watches the block and pixel channels of the BC1 block decoder. Every
// accepted block is decoded here into its sixteen expected pixel words,
// and every accepted pixel word is compared field by field with the oldest
// one still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bc1_pixel_checker (
   input  logic clock,
   input  logic reset,
   bc1_req_if   req_mon,
   bc1_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   block_count,
   output int   four_color_count,
   output int   pixel_count
);
   import bc1_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [1:0] column;
      logic [1:0] row;
      logic       last_pixel;
   } pixel_word_type;

   pixel_word_type pixels_due[$];
   int             mismatches;
   int             blocks;
   int             four_color_blocks;
   int             pixels;

   function automatic color_type widen565(input logic [15:0] packed565);
      color_type  c;
      logic [4:0] r5;
      logic [5:0] g6;
      logic [4:0] b5;
      r5 = packed565[15:11];
      g6 = packed565[10:5];
      b5 = packed565[4:0];
      c.red   = {r5, r5[4:2]};
      c.green = {g6, g6[5:4]};
      c.blue  = {b5, b5[4:2]};
      c.alpha = ALPHA_OPAQUE;
      return c;
   endfunction

   function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                        input int wa, input int wb, input int div);
      int sum;
      sum = wa * int'(a) + wb * int'(b);
      return 8'(sum / div);
   endfunction

   task automatic queue_block_pixels(input logic [15:0] e0, input logic [15:0] e1,
                                     input logic [31:0] idx);
      color_type      pal [4];
      pixel_word_type px;
      logic [1:0]     sel;
      pal[0] = widen565(e0);
      pal[1] = widen565(e1);
      if (e0 > e1) begin
         pal[2].red   = blend(pal[0].red,   pal[1].red,   2, 1, 3);
         pal[2].green = blend(pal[0].green, pal[1].green, 2, 1, 3);
         pal[2].blue  = blend(pal[0].blue,  pal[1].blue,  2, 1, 3);
         pal[2].alpha = ALPHA_OPAQUE;
         pal[3].red   = blend(pal[0].red,   pal[1].red,   1, 2, 3);
         pal[3].green = blend(pal[0].green, pal[1].green, 1, 2, 3);
         pal[3].blue  = blend(pal[0].blue,  pal[1].blue,  1, 2, 3);
         pal[3].alpha = ALPHA_OPAQUE;
         four_color_blocks++;
      end else begin
         pal[2].red   = blend(pal[0].red,   pal[1].red,   1, 1, 2);
         pal[2].green = blend(pal[0].green, pal[1].green, 1, 1, 2);
         pal[2].blue  = blend(pal[0].blue,  pal[1].blue,  1, 1, 2);
         pal[2].alpha = ALPHA_OPAQUE;
         pal[3]       = '{8'h00, 8'h00, 8'h00, ALPHA_TRANSPARENT};
      end
      for (int k = 0; k < PIXELS_PER_BLOCK; k++) begin
         sel           = idx[2*k +: 2];
         px.red        = pal[sel].red;
         px.green      = pal[sel].green;
         px.blue       = pal[sel].blue;
         px.alpha      = pal[sel].alpha;
         px.column     = 2'(k % 4);
         px.row        = 2'(k / 4);
         px.last_pixel = (k == PIXELS_PER_BLOCK - 1);
         pixels_due.push_back(px);
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: pixel %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_pixel_word();
      pixel_word_type want;
      if (pixels_due.size() == 0) begin
         $display("%0t ns: pixel word expected none, got r%0d g%0d b%0d a%0d x%0d y%0d l%0d",
                  $time, rsp_mon.red, rsp_mon.green, rsp_mon.blue, rsp_mon.alpha,
                  rsp_mon.column, rsp_mon.row, rsp_mon.last_pixel);
         mismatches++;
      end else begin
         want = pixels_due.pop_front();
         check_field("red",        want.red,        rsp_mon.red);
         check_field("green",      want.green,      rsp_mon.green);
         check_field("blue",       want.blue,       rsp_mon.blue);
         check_field("alpha",      want.alpha,      rsp_mon.alpha);
         check_field("column",     want.column,     rsp_mon.column);
         check_field("row",        want.row,        rsp_mon.row);
         check_field("last_pixel", want.last_pixel, rsp_mon.last_pixel);
      end
      pixels++;
   endtask

   initial begin
      mismatches        = 0;
      blocks            = 0;
      four_color_blocks = 0;
      pixels            = 0;
      fail_count        = 0;
      pending           = 0;
      block_count       = 0;
      four_color_count  = 0;
      pixel_count       = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            queue_block_pixels(req_mon.endpoint_zero, req_mon.endpoint_one,
                               req_mon.index_bits);
            blocks++;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_pixel_word();
         end
      end
      fail_count       <= mismatches;
      pending          <= pixels_due.size();
      block_count      <= blocks;
      four_color_count <= four_color_blocks;
      pixel_count      <= pixels;
   end

endmodule

[test/tb_bc1_block_decoder.sv]
// ----------------------------------------------------------------------------
// BC1 block decoder testbench
// Feeds the decoder a directed set of blocks (endpoint extremes, equal and
// neighboring endpoints, every palette index) and then random blocks under
// three idle patterns, pausing once until the decoder has drained. A
// separate checker predicts and compares every pixel word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bc1_block_decoder;
   import bc1_pkg::*;

   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_BLOCKS = 100;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   stall_cycles;
   int   fail_count;
   int   pending;
   int   block_count;
   int   four_color_count;
   int   pixel_count;

   bc1_req_if req_chan ();
   bc1_rsp_if rsp_chan ();

   bc1_block_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bc1_pixel_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .fail_count       (fail_count),
      .pending          (pending),
      .block_count      (block_count),
      .four_color_count (four_color_count),
      .pixel_count      (pixel_count)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_chan.ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == STALL_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
         $display("bc1_block_decoder: mismatch");
         $finish;
      end
   end

   task automatic send_block(input logic [15:0] e0, input logic [15:0] e1,
                             input logic [31:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.endpoint_zero <= e0;
      req_chan.endpoint_one  <= e1;
      req_chan.index_bits    <= idx;
      @(posedge clock);
      while (!(req_chan.valid && req_chan.ready)) @(posedge clock);
   endtask

   task automatic send_random_block();
      logic [15:0] e0;
      logic [15:0] e1;
      logic [15:0] tmp;
      logic [31:0] idx;
      e0  = 16'($urandom);
      e1  = 16'($urandom);
      idx = $urandom;
      case ($urandom_range(9))
         5, 6: e1 = e0;
         7: e1 = e0 ^ (16'h1 << $urandom_range(15));
         8: begin
            if (e0 < e1) begin
               tmp = e0;
               e0  = e1;
               e1  = tmp;
            end
         end
         9: begin
            e0 = $urandom_range(1) ? 16'hffff : 16'h0000;
            e1 = $urandom_range(1) ? 16'hffff : 16'h0000;
         end
         default: ;
      endcase
      send_block(e0, e1, idx);
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      clock                  = 1'b0;
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.endpoint_zero = '0;
      req_chan.endpoint_one  = '0;
      req_chan.index_bits    = '0;
      rsp_chan.ready         = 1'b0;
      stall_cycles           = 0;
      send_idle_pct          = 6;
      recv_idle_pct          = 80;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_block(16'h0000, 16'h0000, 32'h0000_0000);
      send_block(16'hffff, 16'hffff, 32'hffff_ffff);
      send_block(16'hffff, 16'h0000, 32'he4e4_e4e4);
      send_block(16'h0000, 16'hffff, 32'he4e4_e4e4);
      send_block(16'hf800, 16'h07e0, 32'h1b1b_1b1b);
      send_block(16'h07e0, 16'h001f, 32'h5555_5555);
      send_block(16'h001f, 16'hf800, 32'haaaa_aaaa);
      send_block(16'h0001, 16'h0000, 32'hffff_ffff);
      send_block(16'h0000, 16'h0001, 32'hffff_ffff);
      send_block(16'h8000, 16'h7fff, 32'h3210_0123);
      send_block(16'h7fff, 16'h8000, 32'h3210_0123);
      send_block(16'h1234, 16'h1234, 32'hc6c6_9393);
      send_block(16'hffff, 16'hfffe, 32'hd8d8_2727);
      send_block(16'hfffe, 16'hffff, 32'hd8d8_2727);
      send_block(16'h5555, 16'haaaa, 32'h0f0f_f0f0);
      send_block(16'haaaa, 16'h5555, 32'h0f0f_f0f0);
      send_block(16'h8410, 16'h7bef, 32'h9c9c_6363);
      send_block(16'h0000, 16'h0000, 32'he4e4_e4e4);

      repeat (PHASE_BLOCKS) send_random_block();
      wait_for_drain();

      send_idle_pct = 80;
      recv_idle_pct = 6;
      repeat (PHASE_BLOCKS) send_random_block();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (PHASE_BLOCKS) send_random_block();

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Decoded %0d blocks (%0d four-color, %0d three-color) into %0d pixels,",
               block_count, four_color_count, block_count - four_color_count,
               pixel_count);
      $display("under sender and receiver stalls, one full drain and back-to-back traffic.");
      if (fail_count == 0) begin
         $display("bc1_block_decoder: match");
      end else begin
         $display("bc1_block_decoder: mismatch");
      end
      $finish;
   end

endmodule
